### rtl/mandelbrot_escape_time_defines.svh
// Assertion macros shared by the escape-time RTL.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape-time assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape-time assertion failed");

`else

`define MET_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/met_pkg.sv
package met_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int FRACTION_BITS = 59;
    localparam int REG_COUNT     = 6;
    localparam int ADDR_BITS     = $clog2(REG_COUNT) + 3;
    localparam int REG_IDX_BITS  = ADDR_BITS - 3;
    localparam int DATA_BITS     = 64;

    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    typedef logic signed [63:0]      t_q;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;

    localparam t_q Q_MAX  = {1'b0, {63{1'b1}}};
    localparam t_q Q_MIN  = {1'b1, {63{1'b0}}};
    localparam t_q FOUR_Q = t_q'(64'd4 << FRACTION_BITS);

    localparam t_reg_idx REG_CENTER_REAL     = t_reg_idx'(0);
    localparam t_reg_idx REG_CENTER_IMAG     = t_reg_idx'(1);
    localparam t_reg_idx REG_PIXEL_HALF_STEP = t_reg_idx'(2);
    localparam t_reg_idx REG_IMAGE_WIDTH     = t_reg_idx'(3);
    localparam t_reg_idx REG_IMAGE_HEIGHT    = t_reg_idx'(4);
    localparam t_reg_idx REG_ITERATION_LIMIT = t_reg_idx'(5);

    // Multiplier operand selection
    localparam logic [2:0] MOP_CX = 3'd0;
    localparam logic [2:0] MOP_CY = 3'd1;
    localparam logic [2:0] MOP_RR = 3'd2;
    localparam logic [2:0] MOP_II = 3'd3;
    localparam logic [2:0] MOP_RI = 3'd4;

    typedef struct packed {
        t_q          center_real;
        t_q          center_imag;
        logic [62:0] pixel_half_step;
        logic [12:0] image_width;
        logic [12:0] image_height;
        t_count      iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic       load_item;
        logic       mul_start;
        logic [2:0] mul_op;
        logic       wr_cr;
        logic       wr_ci;
        logic       clr_z;
        logic       wr_zr2;
        logic       wr_zi2;
        logic       wr_cross;
        logic       upd1;
        logic       upd2;
        logic       out_wr;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic more;
        logic escape;
        logic out_free;
    } t_sts;

endpackage

### rtl/met_if.sv
interface met_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        frame_end;

    modport source (output valid, output pixel_x, output pixel_y, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input frame_end,
                    output ready);
endinterface

interface met_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] iteration_count;
    logic        last_of_frame;
    logic [15:0] frame_max_count;
    logic [15:0] frame_min_count;

    modport source (output valid, output iteration_count, output last_of_frame,
                    output frame_max_count, output frame_min_count, input ready);
    modport sink   (input valid, input iteration_count, input last_of_frame,
                    input frame_max_count, input frame_min_count, output ready);
endinterface

### rtl/met_cfg.sv
module met_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [met_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [met_pkg::DATA_BITS-1:0]     pwdata,
    output logic [met_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    output met_pkg::t_cfg                     o_cfg,
    output logic                              o_limit_wr
);
    import met_pkg::*;

    t_cfg     r_cfg;
    logic     r_limit_wr;
    logic     wr_en;
    t_reg_idx idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_BITS-1:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_real     <= '0;
            r_cfg.center_imag     <= '0;
            r_cfg.pixel_half_step <= '0;
            r_cfg.image_width     <= 13'd1;
            r_cfg.image_height    <= 13'd1;
            r_cfg.iteration_limit <= '0;
            r_limit_wr            <= 1'b0;
        end else begin
            r_limit_wr <= wr_en && (idx == REG_ITERATION_LIMIT);
            if (wr_en) begin
                unique case (idx)
                    REG_CENTER_REAL:     r_cfg.center_real     <= pwdata;
                    REG_CENTER_IMAG:     r_cfg.center_imag     <= pwdata;
                    REG_PIXEL_HALF_STEP: r_cfg.pixel_half_step <= pwdata[62:0];
                    REG_IMAGE_WIDTH:     r_cfg.image_width     <= pwdata[12:0];
                    REG_IMAGE_HEIGHT:    r_cfg.image_height    <= pwdata[12:0];
                    REG_ITERATION_LIMIT: r_cfg.iteration_limit <= pwdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_CENTER_REAL:     prdata = r_cfg.center_real;
            REG_CENTER_IMAG:     prdata = r_cfg.center_imag;
            REG_PIXEL_HALF_STEP: prdata = {1'b0, r_cfg.pixel_half_step};
            REG_IMAGE_WIDTH:     prdata = {51'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT:    prdata = {51'd0, r_cfg.image_height};
            REG_ITERATION_LIMIT: prdata = {{(DATA_BITS-COUNT_BITS){1'b0}},
                                           r_cfg.iteration_limit};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_limit_wr = r_limit_wr;

endmodule

### rtl/met_mul.sv
`include "mandelbrot_escape_time_defines.svh"

module met_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  met_pkg::t_q i_a,
    input  met_pkg::t_q i_b,
    input  logic        i_frac,
    output logic        o_done,
    output met_pkg::t_q o_result
);
    import met_pkg::*;

    t_q                  r_a;
    t_q                  r_b;
    logic                r_frac;
    logic signed [127:0] r_acc;
    logic [1:0]          r_step;
    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    t_q                  r_result;

    logic [32:0]         x_op;
    logic [32:0]         y_op;
    logic signed [65:0]  pp;
    logic signed [127:0] pp_ext;
    logic signed [127:0] n_acc;
    logic signed [127:0] scaled;
    logic [64:0]         hi;
    t_q                  n_result;

    // One 33x33 partial product per cycle; halves carry sign only when they are high halves
    always_comb begin
        case (r_step)
            2'd0: begin
                x_op = {1'b0, r_a[31:0]};
                y_op = {1'b0, r_b[31:0]};
            end
            2'd1: begin
                x_op = {r_a[63], r_a[63:32]};
                y_op = {1'b0, r_b[31:0]};
            end
            2'd2: begin
                x_op = {1'b0, r_a[31:0]};
                y_op = {r_b[63], r_b[63:32]};
            end
            default: begin
                x_op = {r_a[63], r_a[63:32]};
                y_op = {r_b[63], r_b[63:32]};
            end
        endcase
    end

    assign pp     = $signed(x_op) * $signed(y_op);
    assign pp_ext = {{62{pp[65]}}, pp};
    assign n_acc  = r_acc + ((r_step == 2'd0) ? pp_ext :
                             (r_step == 2'd3) ? (pp_ext <<< 64) : (pp_ext <<< 32));

    // When i_frac was set, floor to the fraction grid; then clamp to 64 bits
    assign scaled   = r_frac ? (r_acc >>> FRACTION_BITS) : r_acc;
    assign hi       = scaled[127:63];
    assign n_result = ((&hi) || !(|hi)) ? t_q'(scaled[63:0]) :
                      (scaled[127] ? Q_MIN : Q_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_frac <= i_frac;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
        if (r_fin) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `MET_ASSERT_SAME(a_mul_start_idle, i_clk, i_rst_n, i_start, !r_busy && !r_fin)
    `MET_ASSERT_SAME(a_mul_phase, i_clk, i_rst_n, 1'b1, ($onehot0({r_busy, r_fin, r_done})))

endmodule

### rtl/met_dp.sv
`include "mandelbrot_escape_time_defines.svh"

module met_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  met_pkg::t_cmd i_cmd,
    output met_pkg::t_sts o_sts,
    input  met_pkg::t_cfg i_cfg,
    input  logic          i_limit_wr,
    input  logic [11:0]   i_pixel_x,
    input  logic [11:0]   i_pixel_y,
    input  logic          i_frame_end,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [15:0]   o_iteration_count,
    output logic          o_last_of_frame,
    output logic [15:0]   o_frame_max_count,
    output logic [15:0]   o_frame_min_count
);
    import met_pkg::*;

    function automatic t_q sat_add(t_q a, t_q b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return t_q'(s[63:0]);
    endfunction

    function automatic t_q sat_sub(t_q a, t_q b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return t_q'(s[63:0]);
    endfunction

    logic [11:0] r_px;
    logic [11:0] r_py;
    logic        r_last;
    t_q          r_cr;
    t_q          r_ci;
    t_q          r_zr;
    t_q          r_zi;
    t_q          r_zr2;
    t_q          r_zi2;
    t_q          r_cross;
    t_count      r_n;
    t_count      r_max;
    t_count      r_min;
    logic        r_out_valid;
    t_count      r_out_count;
    logic        r_out_last;
    t_count      r_out_max;
    t_count      r_out_min;

    logic [12:0]        w_c;
    logic [12:0]        h_c;
    logic signed [14:0] kx;
    logic signed [14:0] ky;
    t_q                 mul_a;
    t_q                 mul_b;
    logic               mul_frac;
    logic               mul_done;
    t_q                 mul_res;
    t_count             n_max;
    t_count             n_min;

    assign w_c = (i_cfg.image_width  > MAX_WIDTH)  ? MAX_WIDTH  : i_cfg.image_width;
    assign h_c = (i_cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : i_cfg.image_height;
    assign kx  = $signed({2'b00, r_px, 1'b0}) - $signed({2'b00, w_c}) + 15'sd1;
    assign ky  = $signed({2'b00, r_py, 1'b0}) - $signed({2'b00, h_c}) + 15'sd1;

    always_comb begin
        unique case (i_cmd.mul_op)
            MOP_CX: begin
                mul_a    = {{49{kx[14]}}, kx};
                mul_b    = {1'b0, i_cfg.pixel_half_step};
                mul_frac = 1'b0;
            end
            MOP_CY: begin
                mul_a    = {{49{ky[14]}}, ky};
                mul_b    = {1'b0, i_cfg.pixel_half_step};
                mul_frac = 1'b0;
            end
            MOP_RR: begin
                mul_a    = r_zr;
                mul_b    = r_zr;
                mul_frac = 1'b1;
            end
            MOP_II: begin
                mul_a    = r_zi;
                mul_b    = r_zi;
                mul_frac = 1'b1;
            end
            MOP_RI: begin
                mul_a    = r_zr;
                mul_b    = r_zi;
                mul_frac = 1'b1;
            end
            default: begin
                mul_a    = '0;
                mul_b    = '0;
                mul_frac = 1'b0;
            end
        endcase
    end

    met_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_frac   (mul_frac),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign n_max = (r_n > r_max) ? r_n : r_max;
    assign n_min = (r_n < r_min) ? r_n : r_min;

    assign o_sts.mul_done = mul_done;
    assign o_sts.more     = r_n < i_cfg.iteration_limit;
    assign o_sts.escape   = sat_add(r_zr2, r_zi2) > FOUR_Q;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_max       <= '0;
            r_min       <= '0;
        end else begin
            if (i_cmd.out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_limit_wr) begin
                r_min <= i_cfg.iteration_limit;
            end else if (i_cmd.out_wr) begin
                if (r_last) begin
                    r_max <= '0;
                    r_min <= i_cfg.iteration_limit;
                end else begin
                    r_max <= n_max;
                    r_min <= n_min;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_px   <= i_pixel_x;
            r_py   <= i_pixel_y;
            r_last <= i_frame_end;
        end
        if (i_cmd.wr_cr) begin
            r_cr <= sat_add(i_cfg.center_real, mul_res);
        end
        if (i_cmd.wr_ci) begin
            r_ci <= sat_add(i_cfg.center_imag, mul_res);
        end
        if (i_cmd.clr_z) begin
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end else if (i_cmd.upd2) begin
            r_zr <= sat_add(r_zr2, r_cr);
            r_zi <= sat_add(r_cross, r_ci);
            r_n  <= r_n + t_count'(1);
        end
        if (i_cmd.wr_zr2) begin
            r_zr2 <= mul_res;
        end else if (i_cmd.upd1) begin
            r_zr2 <= sat_sub(r_zr2, r_zi2);
        end
        if (i_cmd.wr_zi2) begin
            r_zi2 <= mul_res;
        end
        if (i_cmd.wr_cross) begin
            r_cross <= mul_res;
        end else if (i_cmd.upd1) begin
            r_cross <= sat_add(r_cross, r_cross);
        end
        if (i_cmd.out_wr) begin
            r_out_count <= r_n;
            r_out_last  <= r_last;
            r_out_max   <= n_max;
            r_out_min   <= n_min;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_last_of_frame   = r_out_last;
    assign o_frame_max_count = r_out_max;
    assign o_frame_min_count = r_out_min;

    `MET_ASSERT_SAME(a_out_slot_free, i_clk, i_rst_n, i_cmd.out_wr, !r_out_valid || i_out_ready)
    `MET_ASSERT_SAME(a_count_below_limit, i_clk, i_rst_n, i_cmd.upd2, r_n < i_cfg.iteration_limit)
    `MET_ASSERT_NEXT(a_out_min_max, i_clk, i_rst_n, i_cmd.out_wr, (r_out_min <= r_out_count) && (r_out_count <= r_out_max))

endmodule

### rtl/met_ctl.sv
module met_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  met_pkg::t_sts i_sts,
    output met_pkg::t_cmd o_cmd
);
    import met_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CX   = 4'd1;
    localparam logic [3:0] S_CXW  = 4'd2;
    localparam logic [3:0] S_CYW  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_RRW  = 4'd5;
    localparam logic [3:0] S_IIW  = 4'd6;
    localparam logic [3:0] S_ESC  = 4'd7;
    localparam logic [3:0] S_RIW  = 4'd8;
    localparam logic [3:0] S_UPD1 = 4'd9;
    localparam logic [3:0] S_UPD2 = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_CX;
                end
            end
            S_CX: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MOP_CX;
                n_state         = S_CXW;
            end
            S_CXW: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_cr     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_CY;
                    n_state         = S_CYW;
                end
            end
            S_CYW: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_ci = 1'b1;
                    o_cmd.clr_z = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.more) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_RR;
                    n_state         = S_RRW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RRW: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_zr2    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_II;
                    n_state         = S_IIW;
                end
            end
            S_IIW: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_zi2 = 1'b1;
                    n_state      = S_ESC;
                end
            end
            S_ESC: begin
                if (i_sts.escape) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_RI;
                    n_state         = S_RIW;
                end
            end
            S_RIW: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_cross = 1'b1;
                    n_state        = S_UPD1;
                end
            end
            S_UPD1: begin
                o_cmd.upd1 = 1'b1;
                n_state    = S_UPD2;
            end
            S_UPD2: begin
                o_cmd.upd2 = 1'b1;
                n_state    = S_CHK;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/mandelbrot_escape_time.sv
// Throughput: one pixel at a time; the pixel input is ready again the cycle after the
// result is registered. Each 64x64 product is summed from 33x33 partial products on
// the single multiplier.
// Reset: synchronous, active low; control, config and frame max/min registers reset.
module mandelbrot_escape_time (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    met_pix_if.sink                       i_pix,
    met_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [met_pkg::ADDR_BITS-1:0] paddr,
    input  logic [met_pkg::DATA_BITS-1:0] pwdata,
    output logic [met_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import met_pkg::*;

    t_cfg cfg;
    logic limit_wr;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    met_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_limit_wr (limit_wr)
    );

    met_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    met_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg             (cfg),
        .i_limit_wr        (limit_wr),
        .i_pixel_x         (i_pix.pixel_x),
        .i_pixel_y         (i_pix.pixel_y),
        .i_frame_end       (i_pix.frame_end),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_iteration_count (o_res.iteration_count),
        .o_last_of_frame   (o_res.last_of_frame),
        .o_frame_max_count (o_res.frame_max_count),
        .o_frame_min_count (o_res.frame_min_count)
    );

    assign i_pix.ready = in_ready;

endmodule
